// ===== rtl/two_class_alternating_lock_arbiter_core_defines.svh =====
// Assertion macros shared by the arbiter modules.
`ifndef TWO_CLASS_ALTERNATING_LOCK_ARBITER_CORE_DEFINES_SVH
`define TWO_CLASS_ALTERNATING_LOCK_ARBITER_CORE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define TCAL_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tcal assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define TCAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcal assertion failed");

`endif

// ===== rtl/tcal_pkg.sv =====
package tcal_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;
    localparam int ID_W            = 8;
    localparam int STATUS_W        = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED     = 3'd0,
        ST_QUEUED      = 3'd1,
        ST_FULL        = 3'd2,
        ST_HANDED      = 3'd3,
        ST_IDLE        = 3'd4,
        ST_BAD_RELEASE = 3'd5
    } status_t;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture the input word
        logic exec;   // decide and update arbiter state
    } cmd_t;

endpackage

// ===== rtl/tcal_ctrl.sv =====
module tcal_ctrl
    import tcal_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

`include "two_class_alternating_lock_arbiter_core_defines.svh"

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);
    assign cmd.load  = in_valid && in_ready;
    assign cmd.exec  = (state_reg == S_EXEC);

    `TCAL_ASSERT_ALWAYS(a_ready_valid_excl, clk, rst_n, !(in_ready && out_valid))
    `TCAL_ASSERT_NEXT(a_load_then_exec, clk, rst_n, cmd.load, cmd.exec)
    `TCAL_ASSERT_NEXT(a_exec_then_resp, clk, rst_n, cmd.exec, out_valid && !cmd.exec)

endmodule

// ===== rtl/tcal_dp.sv =====
module tcal_dp
    import tcal_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic                kind,
    input  logic                category,
    input  logic [ID_W-1:0]     requester_id,
    output logic [STATUS_W-1:0] status,
    output logic                grant_valid,
    output logic [ID_W-1:0]     grant_id,
    output logic                grant_category
);

`include "two_class_alternating_lock_arbiter_core_defines.svh"

    localparam int SB  = (ID_BITS < ID_W) ? ID_BITS : ID_W;  // kept id bits
    localparam int IDX = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SW  = IDX + 2;

    // latched input word
    logic          kind_reg;
    logic          cat_reg;
    logic [SB-1:0] id_reg;

    // arbiter state
    logic           busy_reg, busy_next;
    logic           holder_reg, holder_next;
    logic [IDX-1:0] head_reg [2];
    logic [IDX-1:0] head_next [2];
    logic [CW-1:0]  cnt_reg [2];
    logic [CW-1:0]  cnt_next [2];

    // wait queues, one memory each
    logic [SB-1:0] mem0 [QUEUE_DEPTH];
    logic [SB-1:0] mem1 [QUEUE_DEPTH];
    logic [SB-1:0] rd0_reg;
    logic [SB-1:0] rd1_reg;

    // result word
    status_t       status_reg, status_next;
    logic          gvalid_reg, gvalid_next;
    logic          gcat_reg, gcat_next;
    logic [SB-1:0] gid_reg, gid_next;
    logic          from_mem_reg, from_mem_next;

    logic           enq;
    logic           deq;
    logic           deq_cat;
    logic [IDX-1:0] tail;
    logic [SW-1:0]  tail_sum;
    logic [IDX-1:0] head_inc;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            cat_reg  <= category;
            id_reg   <= requester_id[SB-1:0];
        end
    end

    // tail of the queue of the requester's category
    assign tail_sum = SW'(head_reg[cat_reg]) + SW'(cnt_reg[cat_reg]);
    assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? IDX'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : IDX'(tail_sum);

    always_comb
    begin
        busy_next     = busy_reg;
        holder_next   = holder_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        status_next   = ST_IDLE;
        gvalid_next   = 1'b0;
        gcat_next     = 1'b0;
        gid_next      = '0;
        from_mem_next = 1'b0;
        enq           = 1'b0;
        deq           = 1'b0;
        deq_cat       = !holder_reg;
        head_inc      = '0;
        if (kind_reg == KIND_REQUEST)
        begin
            if (!busy_reg && (cnt_reg[!cat_reg] == '0))
            begin
                busy_next   = 1'b1;
                holder_next = cat_reg;
                status_next = ST_GRANTED;
                gvalid_next = 1'b1;
                gcat_next   = cat_reg;
                gid_next    = id_reg;
            end
            else if (cnt_reg[cat_reg] == CW'(QUEUE_DEPTH))
            begin
                status_next = ST_FULL;
            end
            else
            begin
                enq               = 1'b1;
                cnt_next[cat_reg] = cnt_reg[cat_reg] + 1'b1;
                status_next       = ST_QUEUED;
            end
        end
        else
        begin
            if (!busy_reg)
            begin
                status_next = ST_BAD_RELEASE;
            end
            else
            begin
                // opposite category first, then the holder's own
                if (cnt_reg[!holder_reg] != '0)
                begin
                    deq     = 1'b1;
                    deq_cat = !holder_reg;
                end
                else if (cnt_reg[holder_reg] != '0)
                begin
                    deq     = 1'b1;
                    deq_cat = holder_reg;
                end
                if (deq)
                begin
                    head_inc           = (head_reg[deq_cat] == IDX'(QUEUE_DEPTH - 1)) ? '0
                                         : head_reg[deq_cat] + 1'b1;
                    head_next[deq_cat] = head_inc;
                    cnt_next[deq_cat]  = cnt_reg[deq_cat] - 1'b1;
                    holder_next        = deq_cat;
                    status_next        = ST_HANDED;
                    gvalid_next        = 1'b1;
                    gcat_next          = deq_cat;
                    from_mem_next      = 1'b1;
                end
                else
                begin
                    busy_next   = 1'b0;
                    status_next = ST_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            holder_reg  <= 1'b0;
            head_reg[0] <= '0;
            head_reg[1] <= '0;
            cnt_reg[0]  <= '0;
            cnt_reg[1]  <= '0;
        end
        else if (cmd.exec)
        begin
            busy_reg   <= busy_next;
            holder_reg <= holder_next;
            head_reg   <= head_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg   <= status_next;
            gvalid_reg   <= gvalid_next;
            gcat_reg     <= gcat_next;
            gid_reg      <= gid_next;
            from_mem_reg <= from_mem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && enq && !cat_reg)
        begin
            mem0[tail] <= id_reg;
        end
        if (cmd.exec)
        begin
            rd0_reg <= mem0[head_reg[0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && enq && cat_reg)
        begin
            mem1[tail] <= id_reg;
        end
        if (cmd.exec)
        begin
            rd1_reg <= mem1[head_reg[1]];
        end
    end

    assign status         = status_reg;
    assign grant_valid    = gvalid_reg;
    assign grant_category = gcat_reg;
    assign grant_id       = from_mem_reg ? (gcat_reg ? ID_W'(rd1_reg) : ID_W'(rd0_reg))
                                         : ID_W'(gid_reg);

    `TCAL_ASSERT_ALWAYS(a_cnt0_bound, clk, rst_n, cnt_reg[0] <= CW'(QUEUE_DEPTH))
    `TCAL_ASSERT_ALWAYS(a_cnt1_bound, clk, rst_n, cnt_reg[1] <= CW'(QUEUE_DEPTH))
    `TCAL_ASSERT_NEXT(a_handover_busy, clk, rst_n, cmd.exec && deq,
                      busy_reg && gvalid_reg && (holder_reg == gcat_reg))

endmodule

// ===== rtl/two_class_alternating_lock_arbiter_core.sv =====
// channel | signals                                          | direction
// --------+--------------------------------------------------+----------
// input   | in_valid/in_ready, kind, category, requester_id  | in
// output  | out_valid/out_ready, status, grant_valid,        | out
//         | grant_id, grant_category                         |
//
// Sequence: each word passes through accept, execute and present, the
//   controller's three-state sequence; output stalls hold the present step longer.
// Reset: rst_n asynchronous, active low; clears holder, heads and counts.
//   The queue memories are not cleared: only entries inside a count are read.
// Stalls: one word in flight; in_ready is low until the result is taken.
module two_class_alternating_lock_arbiter_core
    import tcal_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // request / release words
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic                category,
    input  logic [ID_W-1:0]     requester_id,
    // result words
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic                grant_valid,
    output logic [ID_W-1:0]     grant_id,
    output logic                grant_category
);

    cmd_t cmd;

    // sequencer: accept, execute one decision, hold result until taken
    tcal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // holder flag, two FIFO queues and the grant decision
    tcal_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .kind           (kind),
        .category       (category),
        .requester_id   (requester_id),
        .status         (status),
        .grant_valid    (grant_valid),
        .grant_id       (grant_id),
        .grant_category (grant_category)
    );

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import tcal_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_ready;
    logic                kind           = KIND_REQUEST;
    logic                category       = 1'b0;
    logic [ID_W-1:0]     requester_id   = '0;
    logic                out_valid;
    logic                out_ready      = 1'b0;
    logic [STATUS_W-1:0] status;
    logic                grant_valid;
    logic [ID_W-1:0]     grant_id;
    logic                grant_category;

    // Shared knobs between the driver and the output-side ready process.
    bit calm        = 1'b0;  // no idling on either side while set
    bit rx_hold_req = 1'b0;  // ask the output side for one long hold-off

    localparam int RANDOM_WORDS = 700;
    localparam int LONG_HOLD    = 300;

    // One expected result word.
    typedef struct {
        status_t         st;
        logic            gvalid;
        logic [ID_W-1:0] gid;
        logic            gcat;
    } grant_outcome_t;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the arbiter state, predicts one result word per
    // accepted input word and checks results in order.
    // ------------------------------------------------------------------
    class grant_scoreboard;
        bit              busy;
        bit              holder_cat;
        logic [ID_W-1:0] waiters0[$];
        logic [ID_W-1:0] waiters1[$];
        grant_outcome_t  pending_outcomes[$];
        int              fails;

        function int waiting(bit c);
            return c ? waiters1.size() : waiters0.size();
        endfunction

        function logic [ID_W-1:0] take_head(bit c);
            return c ? waiters1.pop_front() : waiters0.pop_front();
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        // Update the mirrored state for one accepted word and queue the outcome.
        function void note_word(logic k, logic c, logic [ID_W-1:0] id);
            grant_outcome_t o;
            bit             nxt;
            o = '{ST_IDLE, 1'b0, '0, 1'b0};
            if (k == KIND_REQUEST)
            begin
                if (!busy && waiting(!c) == 0)
                begin
                    busy       = 1'b1;
                    holder_cat = c;
                    o          = '{ST_GRANTED, 1'b1, id, c};
                end
                else if (waiting(c) >= QUEUE_DEPTH_DEF)
                begin
                    o.st = ST_FULL;
                end
                else
                begin
                    if (c) waiters1.push_back(id);
                    else   waiters0.push_back(id);
                    o.st = ST_QUEUED;
                end
            end
            else if (!busy)
            begin
                o.st = ST_BAD_RELEASE;
            end
            else if (waiting(!holder_cat) == 0 && waiting(holder_cat) == 0)
            begin
                busy = 1'b0;   // holder category is kept while idle
                o.st = ST_IDLE;
            end
            else
            begin
                // opposite category first, else own category
                nxt        = (waiting(!holder_cat) != 0) ? !holder_cat : holder_cat;
                o          = '{ST_HANDED, 1'b1, take_head(nxt), nxt};
                holder_cat = nxt;
            end
            pending_outcomes.push_back(o);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic gv,
                                   logic [ID_W-1:0] gid, logic gcat);
            grant_outcome_t o;
            if (pending_outcomes.size() == 0)
            begin
                $error("result word with nothing expected: status=%0d", st);
                fails++;
                return;
            end
            o = pending_outcomes.pop_front();
            if (st !== o.st)
            begin
                $error("status: expected %0d, got %0d", o.st, st);
                fails++;
            end
            if (gv !== o.gvalid)
            begin
                $error("grant_valid: expected %0d, got %0d", o.gvalid, gv);
                fails++;
            end
            if (gid !== o.gid)
            begin
                $error("grant_id: expected 0x%02h, got 0x%02h", o.gid, gid);
                fails++;
            end
            if (gcat !== o.gcat)
            begin
                $error("grant_category: expected %0d, got %0d", o.gcat, gcat);
                fails++;
            end
        endfunction
    endclass

    grant_scoreboard sb = new();

    // ------------------------------------------------------------------
    // DUT
    // ------------------------------------------------------------------
    two_class_alternating_lock_arbiter_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .category       (category),
        .requester_id   (requester_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .grant_valid    (grant_valid),
        .grant_id       (grant_id),
        .grant_category (grant_category)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Idle lengths: mostly none, some short, a few long.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)    return 0;
        if (r < 60)  return 0;
        if (r < 92)  return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one word after an optional gap; returns once it is accepted.
    // Inputs change on the falling edge, the handshake is seen on the rising edge.
    task automatic send_word(logic k, logic c, logic [ID_W-1:0] id, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        kind         <= k;
        category     <= c;
        requester_id <= id;
        do @(posedge clk); while (!in_ready);
        sb.note_word(k, c, id);
    endtask

    // Sender pause: valid dropped, nothing offered until every result word
    // has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random ready with an occasional long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int hold;
        int g;
        hold = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                hold        = LONG_HOLD;
                rx_hold_req = 1'b0;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                g = pick_gap();
                if (g == 0)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    out_ready <= 1'b0;
                    hold = g - 1;
                end
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, grant_valid, grant_id, grant_category);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int  sent;
        int  seg_len;
        int  mode;
        int  waited;
        bit  burst_cat;
        bit  k;
        bit  c;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        // release with nobody holding
        send_word(KIND_RELEASE, 1'b0, 8'h5A, 0);
        // free resource: immediate grant, lowest id
        send_word(KIND_REQUEST, 1'b0, 8'h00, 0);
        // class 1 piles up behind the holder; the 17th word finds its queue full
        for (int i = 0; i <= QUEUE_DEPTH_DEF; i++)
            send_word(KIND_REQUEST, 1'b1, 8'hFF - i[ID_W-1:0], 0);
        send_word(KIND_REQUEST, 1'b0, 8'hAA, 0);
        // hand-overs alternate: class 1, class 0, class 1, then class 1 again
        // once class 0 is empty
        repeat (4) send_word(KIND_RELEASE, 1'b1, 8'h55, 0);
        wait_drained();

        // --- random part ---
        // Segments of different flavor: balanced traffic, a flood of requests
        // mostly of one class (drives the full-queue path), release-heavy
        // traffic (drains queues and reaches idle / release-while-idle).
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            seg_len   = $urandom_range(20, 60);
            mode      = $urandom_range(0, 3);
            burst_cat = 1'($urandom_range(0, 1));
            calm      = (mode == 3) || ($urandom_range(0, 5) == 0);
            for (int j = 0; j < seg_len && sent < RANDOM_WORDS; j++)
            begin
                case (mode)
                    1:       k = ($urandom_range(0, 99) < 15);
                    2:       k = ($urandom_range(0, 99) < 75);
                    default: k = ($urandom_range(0, 99) < 45);
                endcase
                c = (mode == 1 && $urandom_range(0, 99) < 85) ? burst_cat
                                                              : 1'($urandom_range(0, 1));
                send_word(k ? KIND_RELEASE : KIND_REQUEST, c,
                          ID_W'($urandom_range(0, 255)), pick_gap());
                sent++;
                // long output hold-off while words keep coming in
                if (sent == 150)
                    rx_hold_req = 1'b1;
                // sender pauses until the pipe is empty
                if (sent == 400 || sent == 620)
                    wait_drained();
            end
        end
        calm = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;

        // let every expected word come back, with a bound
        waited = 0;
        while (sb.pending() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending() != 0)
        begin
            $error("%0d result words never arrived", sb.pending());
            sb.fails++;
        end
        repeat (10) @(posedge clk);

        if (sb.fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
